@@ src/nfec_pkg.sv @@
// ---------------------------------------------------------------------------
// nfec_pkg: shared types and constants for the Nova escape-time counter
// Q8.24 word limits, config register indexes, sequencer states and a saturation helper.
// ---------------------------------------------------------------------------
package nfec_pkg;

	localparam int WORD_W = 32;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

	// Configuration register indexes
	localparam logic [0:0] REG_RELAX = 1'b0;
	localparam logic [0:0] REG_MAXIT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TEST,
		ST_X2,
		ST_X3,
		ST_Y2,
		ST_Y3,
		ST_T1,
		ST_FX,
		ST_T2,
		ST_FY,
		ST_FPY,
		ST_D1,
		ST_D2,
		ST_DEN,
		ST_N1,
		ST_N2,
		ST_N3,
		ST_N4,
		ST_DIVX,
		ST_DIVY,
		ST_UPX,
		ST_UPY,
		ST_DONE
	} state_t;

	function automatic logic signed [WORD_W-1:0] sat64(input logic signed [63:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) r = WORD_MAX;
		else if (v < -64'sh0000_0000_8000_0000) r = WORD_MIN;
		else r = v[WORD_W-1:0];
		return r;
	endfunction

endpackage

@@ src/nfec_div.sv @@
// ---------------------------------------------------------------------------
// nfec_div: fixed-point restoring divider
// Computes n/d (d>0) truncated toward zero, saturated, one bit per cycle.
// ---------------------------------------------------------------------------
module nfec_div #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [nfec_pkg::WORD_W-1:0]   num,
	input  logic signed [nfec_pkg::WORD_W-1:0]   den,
	output logic                                 busy,
	output logic                                 done,
	output logic signed [nfec_pkg::WORD_W-1:0]   quo
);
	localparam int SW = nfec_pkg::WORD_W + FRAC_BITS + 1;
	localparam int CW = $clog2(SW + 1);

	logic [SW-1:0] num_q;
	logic [nfec_pkg::WORD_W:0] rem_q;
	logic [SW-1:0] q_q;
	logic [nfec_pkg::WORD_W-1:0] d_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	logic [nfec_pkg::WORD_W+1:0] rem_sh;
	logic [nfec_pkg::WORD_W+1:0] rem_sub;
	logic [nfec_pkg::WORD_W:0] abs_n;
	logic [SW-1:0] limit;

	assign abs_n = num[nfec_pkg::WORD_W-1] ? (33'd0 - {num[nfec_pkg::WORD_W-1], num})
		: {1'b0, num};
	assign rem_sh = {rem_q, num_q[SW-1]};
	assign rem_sub = rem_sh - {2'b00, d_q};
	assign limit = neg_q ? SW'(33'h1_0000_0000 >> 1) : SW'(32'h7FFF_FFFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= SW'(abs_n) << FRAC_BITS;
			rem_q <= '0;
			q_q <= '0;
			d_q <= den;
			neg_q <= num[nfec_pkg::WORD_W-1];
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!rem_sub[nfec_pkg::WORD_W+1]) begin
				rem_q <= rem_sub[nfec_pkg::WORD_W:0];
				q_q <= {q_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[nfec_pkg::WORD_W:0];
				q_q <= {q_q[SW-2:0], 1'b0};
			end
		end
	end

	logic [SW-1:0] qs;
	assign qs = (q_q > limit) ? limit : q_q;
	assign quo = neg_q ? nfec_pkg::WORD_W'(SW'(0) - qs) : qs[nfec_pkg::WORD_W-1:0];
	assign busy = busy_q;
	assign done = done_q;
endmodule

@@ src/nova_fractal_escape_count_top.sv @@
// ---------------------------------------------------------------------------
// nova_fractal_escape_count_top: Nova fractal (z^3-1) escape-time counter
// One shared saturating multiplier and one serial divider under a sequencer.
// ---------------------------------------------------------------------------
// Per pass: the sequencer steps through the multiplier states in order; at
//   Q8.24 the pass time is set by the two serial divides, x then y (both are
//   skipped when the derivative is zero).
// Throughput: one item at a time; busy stays high from start until the
//   done strobe. The receiver cannot stall: done is a one-cycle strobe.
// Reset: arst_n clears control and sets the registers to R=1.0, limit 256.
module nova_fractal_escape_count_top #(
	parameter int FRAC_BITS = 24,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [31:0]       c_re,
	input  logic signed [31:0]       c_im,
	output logic                     done,
	output logic [COUNT_WIDTH-1:0]   iteration_count,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [0:0]               cfg_index,
	input  logic [31:0]              cfg_data
);
	localparam int W = nfec_pkg::WORD_W;
	typedef logic signed [W-1:0] word_t;

	nfec_pkg::state_t state_q, state_d;

	logic [30:0] relax_q;
	logic [15:0] maxit_q;
	word_t cre_q, cim_q, x_q, y_q, r_q;
	word_t x2_q, x3_q, y2_q, y3_q, t_q, fx_q, fy_q, fpx_q, fpy_q, den_q;
	word_t nx_q, ny_q, dx_q, dy_q;
	logic [COUNT_WIDTH-1:0] n_q;

	// Shared multiplier: floor shift and saturation, one product per cycle
	word_t ma, mb, mres;
	logic signed [2*W-1:0] prod;
	assign prod = ma * mb;
	assign mres = nfec_pkg::sat64(64'(prod >>> FRAC_BITS));

	// Saturating helpers (combinational, narrow)
	function automatic word_t qadd(input word_t a, input word_t b);
		return nfec_pkg::sat64(64'(a) + 64'(b));
	endfunction
	function automatic word_t qsub(input word_t a, input word_t b);
		return nfec_pkg::sat64(64'(a) - 64'(b));
	endfunction
	function automatic word_t qk(input word_t a, input logic [2:0] k);
		return nfec_pkg::sat64(64'(a) * 64'(k));
	endfunction

	word_t one_w;
	assign one_w = nfec_pkg::sat64(64'sd1 <<< FRAC_BITS);
	word_t rr_w;
	assign rr_w = word_t'({1'b0, relax_q});

	// Divider
	logic div_start, div_busy, div_done;
	word_t dnum, dquo;
	nfec_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(dnum), .den(den_q),
		.busy(div_busy), .done(div_done), .quo(dquo)
	);

	logic cmax_hit;
	assign cmax_hit = (n_q == {COUNT_WIDTH{1'b1}});
	logic go_on;
	assign go_on = (r_q < rr_w) && (32'(n_q) < 32'(maxit_q)) && !cmax_hit;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nfec_pkg::ST_IDLE: if (start) state_d = nfec_pkg::ST_TEST;
			nfec_pkg::ST_TEST: state_d = go_on ? nfec_pkg::ST_X2 : nfec_pkg::ST_DONE;
			nfec_pkg::ST_X2:  state_d = nfec_pkg::ST_X3;
			nfec_pkg::ST_X3:  state_d = nfec_pkg::ST_Y2;
			nfec_pkg::ST_Y2:  state_d = nfec_pkg::ST_Y3;
			nfec_pkg::ST_Y3:  state_d = nfec_pkg::ST_T1;
			nfec_pkg::ST_T1:  state_d = nfec_pkg::ST_FX;
			nfec_pkg::ST_FX:  state_d = nfec_pkg::ST_T2;
			nfec_pkg::ST_T2:  state_d = nfec_pkg::ST_FY;
			nfec_pkg::ST_FY:  state_d = nfec_pkg::ST_FPY;
			nfec_pkg::ST_FPY: state_d = nfec_pkg::ST_D1;
			nfec_pkg::ST_D1:  state_d = nfec_pkg::ST_D2;
			nfec_pkg::ST_D2:  state_d = nfec_pkg::ST_DEN;
			nfec_pkg::ST_DEN: state_d = nfec_pkg::ST_N1;
			nfec_pkg::ST_N1:  state_d = nfec_pkg::ST_N2;
			nfec_pkg::ST_N2:  state_d = nfec_pkg::ST_N3;
			nfec_pkg::ST_N3:  state_d = nfec_pkg::ST_N4;
			nfec_pkg::ST_N4:  state_d = (den_q > 0) ? nfec_pkg::ST_DIVX : nfec_pkg::ST_UPX;
			nfec_pkg::ST_DIVX: if (div_done) state_d = nfec_pkg::ST_DIVY;
			nfec_pkg::ST_DIVY: if (div_done) state_d = nfec_pkg::ST_UPX;
			nfec_pkg::ST_UPX: state_d = nfec_pkg::ST_UPY;
			nfec_pkg::ST_UPY: state_d = nfec_pkg::ST_TEST;
			nfec_pkg::ST_DONE: state_d = nfec_pkg::ST_IDLE;
			default: state_d = nfec_pkg::ST_IDLE;
		endcase
	end

	// Multiplier operand select and divider launch
	always_comb begin
		ma = x_q;
		mb = x_q;
		div_start = 1'b0;
		dnum = nx_q;
		unique case (state_q)
			nfec_pkg::ST_X2:  begin ma = x_q; mb = x_q; end
			nfec_pkg::ST_X3:  begin ma = x2_q; mb = x_q; end
			nfec_pkg::ST_Y2:  begin ma = y_q; mb = y_q; end
			nfec_pkg::ST_Y3:  begin ma = y2_q; mb = y_q; end
			nfec_pkg::ST_T1:  begin ma = qk(x_q, 3'd3); mb = y2_q; end
			nfec_pkg::ST_T2:  begin ma = qk(x2_q, 3'd3); mb = y_q; end
			nfec_pkg::ST_FPY: begin ma = qk(x_q, 3'd6); mb = y_q; end
			nfec_pkg::ST_D1:  begin ma = fpx_q; mb = fpx_q; end
			nfec_pkg::ST_D2:  begin ma = fpy_q; mb = fpy_q; end
			nfec_pkg::ST_N1:  begin ma = fx_q; mb = fpx_q; end
			nfec_pkg::ST_N2:  begin ma = fy_q; mb = fpy_q; end
			nfec_pkg::ST_N3:  begin ma = fpx_q; mb = fy_q; end
			nfec_pkg::ST_N4:  begin
				ma = fx_q; mb = fpy_q;
				div_start = (den_q > 0);
				dnum = nx_q;
			end
			nfec_pkg::ST_DIVX: begin
				div_start = div_done;
				dnum = ny_q;
			end
			nfec_pkg::ST_UPX: begin ma = rr_w; mb = dx_q; end
			nfec_pkg::ST_UPY: begin ma = rr_w; mb = dy_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfec_pkg::ST_IDLE;
			relax_q <= 31'd16777216;
			maxit_q <= 16'd256;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					nfec_pkg::REG_RELAX: relax_q <= cfg_data[30:0];
					nfec_pkg::REG_MAXIT: maxit_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			nfec_pkg::ST_IDLE: begin
				cre_q <= c_re; cim_q <= c_im;
				x_q <= '0; y_q <= '0; r_q <= '0; n_q <= '0;
			end
			nfec_pkg::ST_X2: x2_q <= mres;
			nfec_pkg::ST_X3: x3_q <= mres;
			nfec_pkg::ST_Y2: y2_q <= mres;
			nfec_pkg::ST_Y3: begin
				y3_q <= mres;
				fpx_q <= qk(qsub(x2_q, y2_q), 3'd3);
			end
			nfec_pkg::ST_T1: t_q <= mres;
			nfec_pkg::ST_FX: fx_q <= qsub(qsub(x3_q, t_q), one_w);
			nfec_pkg::ST_T2: t_q <= mres;
			nfec_pkg::ST_FY: fy_q <= qsub(t_q, y3_q);
			nfec_pkg::ST_FPY: fpy_q <= mres;
			nfec_pkg::ST_D1: t_q <= mres;
			nfec_pkg::ST_D2: den_q <= qadd(t_q, mres);
			nfec_pkg::ST_N1: t_q <= mres;
			nfec_pkg::ST_N2: nx_q <= qadd(t_q, mres);
			nfec_pkg::ST_N3: t_q <= mres;
			nfec_pkg::ST_N4: begin
				ny_q <= qsub(t_q, mres);
				dx_q <= '0; dy_q <= '0;
			end
			nfec_pkg::ST_DIVX: if (div_done) dx_q <= dquo;
			nfec_pkg::ST_DIVY: if (div_done) dy_q <= dquo;
			nfec_pkg::ST_UPX: begin
				r_q <= qadd(x2_q, y2_q);
				x_q <= qadd(qsub(x_q, mres), cre_q);
			end
			nfec_pkg::ST_UPY: begin
				y_q <= qadd(qsub(y_q, mres), cim_q);
				n_q <= n_q + 1'b1;
			end
			default: ;
		endcase
	end

	// N4 starts the x divide while ny_q is still being written; the x divide
	// reads nx_q, the y divide is launched on the x done strobe when ny_q is settled.
	assign busy = (state_q != nfec_pkg::ST_IDLE);
	assign done = (state_q == nfec_pkg::ST_DONE);
	assign iteration_count = n_q;
	assign cfg_ready = !busy;

	// Assertions
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> state_q == nfec_pkg::ST_IDLE)
		else $error("config write while busy");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy || div_done)
		else $error("divider restarted while busy");
	a_cnt_lim: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(iteration_count) <= 32'(maxit_q) || maxit_q == 16'd0)
		else $error("count beyond limit");
endmodule
